// ===== rtl/core/tdms_pkg.sv =====
// Shared types and constants for the table-driven motion sequencer.
// No dependencies; imported by every module of the block.
package tdms_pkg;

  localparam int NUM_STATES    = 4;
  localparam int NUM_EVENTS    = 4;
  localparam int TIMER_BITS    = 16;
  localparam int STATE_BITS    = 2;
  localparam int EVENT_BITS    = 2;
  localparam int ENTRY_BITS    = STATE_BITS + EVENT_BITS;
  localparam int ACTION_BITS   = 3;
  localparam int CMD_BITS      = 3;
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 64;
  localparam int NS_TABLE_BITS = 32;
  localparam int AC_TABLE_BITS = 48;
  localparam int TO_TABLE_BITS = 64;

  localparam logic [EVENT_BITS-1:0] TIMEOUT_EVENT = 2'd0;
  localparam logic [EVENT_BITS-1:0] START_EVENT   = 2'd0;
  localparam logic [CMD_BITS-1:0]   MOTOR_NONE    = 3'd4;

  // Register index, taken from paddr[4:3] (registers sit on 8-byte steps).
  typedef enum logic [1:0] {
    REG_NEXT_STATE = 2'd0,
    REG_ACTION     = 2'd1,
    REG_TIMEOUT    = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_EVENT = 2'd1,
    OP_START = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef struct packed {
    logic [NS_TABLE_BITS-1:0] next_state_table;
    logic [AC_TABLE_BITS-1:0] action_table;
    logic [TO_TABLE_BITS-1:0] timeout_table;
  } cfg_t;

  typedef struct packed {
    logic [CMD_BITS-1:0]   motor_command;
    logic [STATE_BITS-1:0] current_state;
    logic                  running;
    logic                  timeout_fired;
  } result_t;

endpackage

// ===== rtl/core/tdms_regs.sv =====
// APB-style configuration registers of the motion sequencer.
// Depends on tdms_pkg for the register map and the cfg_t bundle.
module tdms_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tdms_pkg::ADDR_BITS-1:0] paddr,
  input  logic [tdms_pkg::DATA_BITS-1:0] pwdata,
  output logic [tdms_pkg::DATA_BITS-1:0] prdata,
  output logic                         pready,
  output tdms_pkg::cfg_t               cfg
);
  import tdms_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:ADDR_BITS-2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_NEXT_STATE: cfg.next_state_table <= pwdata[NS_TABLE_BITS-1:0];
        REG_ACTION:     cfg.action_table     <= pwdata[AC_TABLE_BITS-1:0];
        REG_TIMEOUT:    cfg.timeout_table    <= pwdata[TO_TABLE_BITS-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NEXT_STATE: prdata = DATA_BITS'(cfg.next_state_table);
      REG_ACTION:     prdata = DATA_BITS'(cfg.action_table);
      REG_TIMEOUT:    prdata = DATA_BITS'(cfg.timeout_table);
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== rtl/core/tdms_step.sv =====
// Sequencer state and the one-pass next-state logic for a single word.
// Depends on tdms_pkg; table contents come from tdms_regs.
module tdms_step (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step_en,
  input  logic [1:0]                      op,
  input  logic [tdms_pkg::EVENT_BITS-1:0] event_code,
  input  tdms_pkg::cfg_t                  cfg,
  output tdms_pkg::result_t               result
);
  import tdms_pkg::*;

  logic [STATE_BITS-1:0]  seq_state, seq_state_next;
  logic [TIMER_BITS-1:0]  ticks_left, ticks_left_next;
  logic                   timer_armed, timer_armed_next;
  logic                   program_on, program_on_next;

  logic                   serve;
  logic [STATE_BITS-1:0]  srv_state;
  logic [EVENT_BITS-1:0]  srv_event;
  logic [ENTRY_BITS-1:0]  entry;
  logic [ACTION_BITS-1:0] act;
  logic [STATE_BITS-1:0]  nxt;
  logic [TIMER_BITS-1:0]  dec;
  logic                   fired;
  op_t                    op_c;

  assign op_c = op_t'(op);
  assign dec  = (ticks_left != '0) ? ticks_left - 1'b1 : ticks_left;

  always_comb begin
    seq_state_next   = seq_state;
    ticks_left_next  = ticks_left;
    timer_armed_next = timer_armed;
    program_on_next  = program_on;
    serve            = 1'b0;
    srv_state        = seq_state;
    srv_event        = event_code;
    fired            = 1'b0;
    case (op_c)
      OP_TICK: begin
        if (program_on && timer_armed) begin
          ticks_left_next = dec;
          if (dec == '0) begin
            fired     = 1'b1;
            serve     = 1'b1;
            srv_event = TIMEOUT_EVENT;
          end
        end
      end
      OP_EVENT: begin
        serve = program_on;
      end
      OP_START: begin
        program_on_next  = 1'b1;
        timer_armed_next = 1'b0;
        ticks_left_next  = '0;
        serve            = 1'b1;
        srv_state        = '0;
        srv_event        = START_EVENT;
      end
      default: begin
        program_on_next = 1'b0;
      end
    endcase

    // Table lookup at state*NUM_EVENTS+event, wrapping over sixteen entries.
    entry = {srv_state, srv_event};
    act   = cfg.action_table[entry*ACTION_BITS +: ACTION_BITS];
    nxt   = cfg.next_state_table[entry*STATE_BITS +: STATE_BITS];

    result.motor_command = MOTOR_NONE;
    if (serve) begin
      seq_state_next = nxt;
      if (!act[ACTION_BITS-1]) begin
        ticks_left_next      = cfg.timeout_table[act[1:0]*TIMER_BITS +: TIMER_BITS];
        timer_armed_next     = 1'b1;
        result.motor_command = act;
      end
    end
    result.current_state = seq_state_next;
    result.running       = program_on_next;
    result.timeout_fired = fired;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state   <= '0;
      ticks_left  <= '0;
      timer_armed <= 1'b0;
      program_on  <= 1'b0;
    end else if (step_en) begin
      seq_state   <= seq_state_next;
      ticks_left  <= ticks_left_next;
      timer_armed <= timer_armed_next;
      program_on  <= program_on_next;
    end
  end

endmodule

// ===== rtl/core/table_driven_motion_sequencer.sv =====
// Top level of the table-driven motion sequencer: input handshake, result register.
// Depends on tdms_pkg, tdms_regs and tdms_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per tick, external
//   event, program start or program stop (op, event_code).
//   Output channel (out_valid/out_ready) returns exactly one word per input
//   word: motor_command, current_state_out, running, timeout_fired.
//   Configuration goes through the APB-style port: next-state table at
//   address 0, action table at 8, timeout table at 16; pready is always high.
// Output: a result shows on the output in the cycle after its input is taken.
// Throughput: one word per cycle while out_ready is high; the whole lookup, timer decrement and
//   compare sit between the sequencer state registers and the result
//   register, so back-to-back words run at full rate.
// Stall: while a result waits with out_ready low, in_ready drops and the
//   state holds; as soon as the result is taken a new word enters in the
//   same cycle.
// Reset: rst (synchronous, active high) clears tables, state, timer, the
//   run flag and the output valid; no clearing pass is needed.
module table_driven_motion_sequencer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      op,
  input  logic [tdms_pkg::EVENT_BITS-1:0] event_code,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tdms_pkg::CMD_BITS-1:0]   motor_command,
  output logic [tdms_pkg::STATE_BITS-1:0] current_state_out,
  output logic                            running,
  output logic                            timeout_fired,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tdms_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [tdms_pkg::DATA_BITS-1:0]  pwdata,
  output logic [tdms_pkg::DATA_BITS-1:0]  prdata,
  output logic                            pready
);
  import tdms_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t out_word;
  logic    accept;

  // Take a new word whenever the result register is empty or being drained.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  tdms_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tdms_step u_step (
    .clk        (clk),
    .rst        (rst),
    .step_en    (accept),
    .op         (op),
    .event_code (event_code),
    .cfg        (cfg),
    .result     (result)
  );

  // Result register: valid is control state, payload loads on accept only.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= result;
    end
  end

  assign motor_command     = out_word.motor_command;
  assign current_state_out = out_word.current_state;
  assign running           = out_word.running;
  assign timeout_fired     = out_word.timeout_fired;

endmodule

// ===== rtl/core/tdms_checker.sv =====
// Port-level checks for the motion sequencer, bound to the top level.
// Depends on tdms_pkg for op codes and the no-motion command.
module tdms_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [1:0]                      op,
  input logic [tdms_pkg::EVENT_BITS-1:0] event_code,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tdms_pkg::CMD_BITS-1:0]   motor_command,
  input logic [tdms_pkg::STATE_BITS-1:0] current_state_out,
  input logic                            running,
  input logic                            timeout_fired
);
  import tdms_pkg::*;

  logic acc;
  assign acc = in_valid && in_ready;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(motor_command)
      && $stable(current_state_out))
    else $error("result dropped or changed while stalled");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    acc |=> out_valid)
    else $error("accepted word gave no result next cycle");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    acc && op == OP_START |=> running)
    else $error("start did not set running");

  a_stop_idles: assert property (@(posedge clk) disable iff (rst)
    acc && op == OP_STOP |=> !running && motor_command == MOTOR_NONE
      && !timeout_fired)
    else $error("stop left program running or issued a command");

  a_fire_running: assert property (@(posedge clk) disable iff (rst)
    out_valid && timeout_fired |-> running)
    else $error("timeout fired while idle");

endmodule

bind table_driven_motion_sequencer tdms_checker u_tdms_checker (
  .clk               (clk),
  .rst               (rst),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .op                (op),
  .event_code        (event_code),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .motor_command     (motor_command),
  .current_state_out (current_state_out),
  .running           (running),
  .timeout_fired     (timeout_fired)
);
